>>> sv/assert_macros.svh
// assertion helpers for the rtl files, included by the cache model
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is applied
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also holds while reset is applied
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> sv/sacache_pkg.sv
// ----------------------------------------------------------------------------
// sacache_pkg
// Shared widths, codes and types of the set associative cache model.
// ----------------------------------------------------------------------------
package sacache_pkg;

    // payload widths
    localparam int KIND_W     = 1;
    localparam int ADDR_W     = 32;
    localparam int IDX_OUT_W  = 5;
    localparam int CNT_W      = 32;
    localparam int WL_W       = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_LOG2    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_MODE = 1'b1;

    // access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // victim policies
    localparam logic MODE_LRU = 1'b0;
    localparam logic MODE_LFU = 1'b1;

    // register reset values
    localparam logic [WL_W-1:0] WAYS_LOG2_RST = '0;
    localparam logic            MODE_RST      = MODE_LFU;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_state;

    // saturating increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

>>> sv/sacache_req_if.sv
// ----------------------------------------------------------------------------
// sacache_req_if
// Access request channel: kind and byte address with valid/ready.
// ----------------------------------------------------------------------------
interface sacache_req_if
    import sacache_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output kind, output address, input ready);
    modport sink   (input valid, input kind, input address, output ready);
endinterface

>>> sv/sacache_rsp_if.sv
// ----------------------------------------------------------------------------
// sacache_rsp_if
// Access result channel: lookup outcome and hit counters with valid/ready.
// ----------------------------------------------------------------------------
interface sacache_rsp_if
    import sacache_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [IDX_OUT_W-1:0] set_index;
    logic [IDX_OUT_W-1:0] way_index;
    logic                 evicted_valid;
    logic                 evicted_dirty;
    logic [CNT_W-1:0]     read_hit_count;
    logic [CNT_W-1:0]     write_hit_count;

    modport source (
        output valid, output hit, output set_index, output way_index,
        output evicted_valid, output evicted_dirty,
        output read_hit_count, output write_hit_count,
        input  ready
    );
    modport sink (
        input  valid, input hit, input set_index, input way_index,
        input  evicted_valid, input evicted_dirty,
        input  read_hit_count, input write_hit_count,
        output ready
    );
endinterface

>>> sv/sacache_ram.sv
// ----------------------------------------------------------------------------
// sacache_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sacache_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int RAM_AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [RAM_AW-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [RAM_AW-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/set_assoc_cache_lru_lfu.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lfu
// Tag and replacement state model of a set associative cache with LRU or
// LFU victim choice, kept in one block RAM.
// ----------------------------------------------------------------------------
// An access is taken in the idle state; the ways of its set are then read
// one after the other through the single read port of the block RAM, whose
// read is registered, and the updated block is written back at the end. The
// scan stops at the first invalid or matching way, so a fill or hit in way k
// ends the scan at that way; a miss in a full set scans every way. The result
// is loaded into the output register together with the write-back. The
// write-back waits while the previous result still sits unaccepted in the
// output register. The next request is taken in the cycle after the
// write-back, while the previous result may still wait on the output
// register. After reset the block RAM is cleared, one block per cycle, over
// all its blocks, whose number is the largest power of two not above
// TOTAL_BLOCKS; no request is taken during that pass. Configuration writes
// are taken at any time but may change only while no access is in flight.
`include "assert_macros.svh"

module set_assoc_cache_lru_lfu
    import sacache_pkg::*;
#(
    parameter int TOTAL_BLOCKS = 32,
    parameter int OFFSET_BITS  = 3,
    parameter int ADDR_BITS    = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sacache_req_if.sink           i_req,
    sacache_rsp_if.source         o_rsp
);

    localparam int BLK_LOG2  = $clog2(TOTAL_BLOCKS + 1) - 1;
    localparam int NBLK      = 1 << BLK_LOG2;
    localparam int BLK_W     = BLK_LOG2;
    localparam int WAY_CNT_W = BLK_LOG2 + 1;
    localparam int WLC_W     = $clog2(BLK_LOG2 + 1);
    localparam int AW        = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int TAG_W     = ADDR_W - OFFSET_BITS;
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        ADDR_W'(((ADDR_W + 1)'(1) << AW) - (ADDR_W + 1)'(1));
    localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(NBLK - 1);

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] stamp;
        logic [CNT_W-1:0] freq;
    } t_entry;

    t_state r_state, n_state;

    // configuration
    logic [WL_W-1:0] r_ways_log2;
    logic            r_mode;

    // request and scan state
    logic [BLK_W-1:0]     r_clr_idx;
    logic                 r_kind;
    logic [BLK_W-1:0]     r_set;
    logic [TAG_W-1:0]     r_tag;
    logic [WAY_CNT_W-1:0] r_rd_way;
    logic                 r_pend;
    logic [BLK_W-1:0]     r_pend_way;
    logic [CNT_W-1:0]     r_best_key;
    logic [BLK_W-1:0]     r_best_way;
    logic                 r_best_dirty;

    // lookup outcome
    logic [BLK_W-1:0] r_way;
    logic             r_hit;
    logic             r_old_dirty;
    logic [CNT_W-1:0] r_old_freq;
    logic             r_ev_valid;
    logic             r_ev_dirty;

    // global counters
    logic [CNT_W-1:0] r_stamp_cnt, n_stamp_cnt;
    logic [CNT_W-1:0] r_rd_hits, n_rd_hits;
    logic [CNT_W-1:0] r_wr_hits, n_wr_hits;

    // result register
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [IDX_OUT_W-1:0] r_out_set;
    logic [IDX_OUT_W-1:0] r_out_way;
    logic                 r_out_ev_valid;
    logic                 r_out_ev_dirty;
    logic [CNT_W-1:0]     r_out_rd_hits;
    logic [CNT_W-1:0]     r_out_wr_hits;

    // block ram ports
    logic             ram_we;
    logic [BLK_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic [BLK_W-1:0] ram_raddr;
    t_entry           rd_ent;

    // combinational helpers
    logic [WLC_W-1:0]  wl;
    logic [5:0]        tag_sh;
    logic [BLK_W-1:0]  set_mask;
    logic [BLK_W-1:0]  way_mask;
    logic [ADDR_W-1:0] addr_m;
    logic [BLK_W-1:0]  req_set;
    logic [TAG_W-1:0]  req_tag;
    logic              accept;
    logic              rd_more;
    logic [CNT_W-1:0]  key;
    logic              ev_match;
    logic              ev_found;
    logic              last_way;
    logic              take_min;
    logic [BLK_W-1:0]  cur_best_way;
    logic              cur_best_dirty;
    logic              scan_done;
    logic              out_free;
    t_entry            new_ent;

    sacache_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NBLK)
    ) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_ent)
    );

    // layout of the current associativity
    always_comb begin
        wl = (32'(r_ways_log2) > BLK_LOG2) ? WLC_W'(BLK_LOG2) : WLC_W'(r_ways_log2);
        tag_sh   = 6'(OFFSET_BITS) + 6'(BLK_LOG2) - 6'(wl);
        set_mask = {BLK_W{1'b1}} >> wl;
        way_mask = {BLK_W{1'b1}} >> (WLC_W'(BLK_LOG2) - wl);
    end

    // address split
    assign addr_m  = i_req.address & ADDR_MASK;
    assign req_set = BLK_W'(addr_m >> OFFSET_BITS) & set_mask;
    assign req_tag = TAG_W'(addr_m >> tag_sh);

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign rd_more  = r_rd_way <= {1'b0, way_mask};

    // evaluation of the way returned by the ram
    always_comb begin
        key            = (r_mode == MODE_LFU) ? rd_ent.freq : rd_ent.stamp;
        ev_match       = rd_ent.valid && (rd_ent.tag == r_tag);
        ev_found       = r_pend && (!rd_ent.valid || ev_match);
        last_way       = r_pend_way == way_mask;
        take_min       = (r_pend_way == '0) || (key < r_best_key);
        cur_best_way   = take_min ? r_pend_way : r_best_way;
        cur_best_dirty = take_min ? rd_ent.dirty : r_best_dirty;
        scan_done      = r_pend && (ev_found || last_way);
    end

    // updated block and counters
    always_comb begin
        n_stamp_cnt   = r_stamp_cnt + CNT_W'(1);
        new_ent.valid = 1'b1;
        new_ent.dirty = r_hit ? (r_old_dirty | r_kind) : r_kind;
        new_ent.tag   = r_tag;
        new_ent.stamp = n_stamp_cnt;
        new_ent.freq  = r_hit ? sat_inc(r_old_freq) : CNT_W'(1);
        n_rd_hits = (r_hit && r_kind == KIND_READ) ? sat_inc(r_rd_hits) : r_rd_hits;
        n_wr_hits = (r_hit && r_kind == KIND_WRITE) ? sat_inc(r_wr_hits) : r_wr_hits;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == BLK_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // state outputs: ram control and request ready
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = BLK_W'(r_set << wl) | r_way;
        ram_wdata   = new_ent;
        ram_raddr   = BLK_W'(r_set << wl) | r_rd_way[BLK_W-1:0];
        i_req.ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            ST_SCAN: begin
            end
            ST_WRITE: begin
                ram_we = out_free;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_ways_log2 <= WAYS_LOG2_RST;
            r_mode      <= MODE_RST;
            r_pend      <= 1'b0;
            r_rd_way    <= '0;
            r_stamp_cnt <= '0;
            r_rd_hits   <= '0;
            r_wr_hits   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + BLK_W'(1);
            end
            // configuration transaction
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WAYS_LOG2:    r_ways_log2 <= i_cfg_data;
                    REG_REPLACE_MODE: r_mode      <= i_cfg_data[0];
                endcase
            end
            // way read sequencing
            if (accept) begin
                r_rd_way <= '0;
                r_pend   <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                if (rd_more) begin
                    r_rd_way <= r_rd_way + WAY_CNT_W'(1);
                end
                r_pend <= rd_more;
            end
            // write-back and counter update
            if (r_state == ST_WRITE && out_free) begin
                r_stamp_cnt <= n_stamp_cnt;
                r_rd_hits   <= n_rd_hits;
                r_wr_hits   <= n_wr_hits;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_req.kind;
            r_set  <= req_set;
            r_tag  <= req_tag;
        end
        if (r_state == ST_SCAN && !r_pend) begin
            r_pend_way <= r_rd_way[BLK_W-1:0];
        end else if (r_state == ST_SCAN) begin
            r_pend_way   <= r_rd_way[BLK_W-1:0];
            r_best_key   <= take_min ? key : r_best_key;
            r_best_way   <= cur_best_way;
            r_best_dirty <= cur_best_dirty;
        end
        // lookup outcome at the end of the scan
        if (r_state == ST_SCAN && scan_done) begin
            r_way       <= ev_found ? r_pend_way : cur_best_way;
            r_hit       <= ev_match;
            r_old_dirty <= rd_ent.dirty;
            r_old_freq  <= rd_ent.freq;
            r_ev_valid  <= !ev_found;
            r_ev_dirty  <= !ev_found && cur_best_dirty;
        end
        // result register load
        if (r_state == ST_WRITE && out_free) begin
            r_out_hit      <= r_hit;
            r_out_set      <= IDX_OUT_W'(r_set);
            r_out_way      <= IDX_OUT_W'(r_way);
            r_out_ev_valid <= r_ev_valid;
            r_out_ev_dirty <= r_ev_dirty;
            r_out_rd_hits  <= n_rd_hits;
            r_out_wr_hits  <= n_wr_hits;
        end
    end

    // result channel
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.hit             = r_out_hit;
    assign o_rsp.set_index       = r_out_set;
    assign o_rsp.way_index       = r_out_way;
    assign o_rsp.evicted_valid   = r_out_ev_valid;
    assign o_rsp.evicted_dirty   = r_out_ev_dirty;
    assign o_rsp.read_hit_count  = r_out_rd_hits;
    assign o_rsp.write_hit_count = r_out_wr_hits;

    // checks
    `ASSERT_CLK_ALWAYS(a_reset_clears, !i_rst_n |=> r_state == ST_CLEAR, "reset did not start clear")
    `ASSERT_CLK(a_out_from_write, $rose(o_rsp.valid) |-> $past(r_state) == ST_WRITE, "result without write-back")
    `ASSERT_CLK(a_hit_no_evict, o_rsp.valid && o_rsp.hit |-> !o_rsp.evicted_valid, "hit with eviction")
    `ASSERT_CLK(a_dirty_needs_evict, o_rsp.valid && o_rsp.evicted_dirty |-> o_rsp.evicted_valid, "dirty without eviction")
    `ASSERT_CLK(a_ram_write_state, ram_we |-> (r_state == ST_CLEAR || r_state == ST_WRITE), "ram write outside clear or write-back")
    `ASSERT_CLK(a_scan_in_set, r_state == ST_SCAN && r_pend |-> r_pend_way <= way_mask, "scan left the set")

endmodule
